>>> design/grv_pkg.sv
// grid raycast visibility: shared types, opcodes and default sizes
// used by every module of the block; depends on nothing
`default_nettype none

package grv_pkg;

    localparam int MAP_WIDTH_DEF  = 64;
    localparam int MAP_HEIGHT_DEF = 64;
    localparam int RAY_COUNT_DEF  = 720;
    localparam int MAX_RADIUS_DEF = 15;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] VIEW_RADIUS_RST = 4'd8;

    // ray steps are signed q2.16, positions signed with 16 fraction bits
    localparam int STEP_W = 18;
    localparam int FRAC_W = 16;
    localparam int POS_W  = 26;

    localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CAST  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef logic signed [STEP_W-1:0] step_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic vis;
        logic seen;
    } mark_t;

    typedef struct packed {
        logic  wall_we;
        logic  wall_wd;
        logic  mark_we;
        mark_t mark_wd;
    } store_ctl_t;

    typedef struct packed {
        logic mark_we;
        logic done;
    } walk_stat_t;

endpackage

`default_nettype wire

>>> design/grv_step_rom.sv
// step rom: cosine and sine step of every ray, built at elaboration from
// an eight-term taylor series; registered read; depends on grv_pkg
`default_nettype none

module grv_step_rom #(
    parameter int RAY_COUNT = grv_pkg::RAY_COUNT_DEF
) (
    input  logic                         clk,
    input  logic [$clog2(RAY_COUNT)-1:0] ray,
    output grv_pkg::step_t               step_x,
    output grv_pkg::step_t               step_y
);
    import grv_pkg::*;

    typedef step_t step_tab_t [RAY_COUNT];

    localparam longint unsigned ONE_Q24 = 64'd1 << 24;
    localparam longint unsigned PI_Q24  = 64'd52707179;
    localparam longint STEP_MAX = 131071;
    localparam longint STEP_MIN = -131072;

    // series divisors, scaled to q.24
    localparam longint unsigned S1 = 64'd6 << 24;
    localparam longint unsigned S2 = 64'd20 << 24;
    localparam longint unsigned S3 = 64'd42 << 24;
    localparam longint unsigned S4 = 64'd72 << 24;
    localparam longint unsigned S5 = 64'd110 << 24;
    localparam longint unsigned S6 = 64'd156 << 24;
    localparam longint unsigned S7 = 64'd210 << 24;
    localparam longint unsigned C1 = 64'd2 << 24;
    localparam longint unsigned C2 = 64'd12 << 24;
    localparam longint unsigned C3 = 64'd30 << 24;
    localparam longint unsigned C4 = 64'd56 << 24;
    localparam longint unsigned C5 = 64'd90 << 24;
    localparam longint unsigned C6 = 64'd132 << 24;
    localparam longint unsigned C7 = 64'd182 << 24;

    function automatic step_t taylor_q16(longint unsigned t, logic odd);
        longint unsigned t2;
        longint unsigned mag;
        longint          s;
        longint          r;
        t2  = (t * t + (ONE_Q24 >> 1)) >> 24;
        mag = odd ? t : ONE_Q24;
        s   = longint'(mag);
        for (int i = 1; i < 8; i++)
        begin
            case (i)
                1: mag = odd ? (mag * t2 + S1 / 2) / S1 : (mag * t2 + C1 / 2) / C1;
                2: mag = odd ? (mag * t2 + S2 / 2) / S2 : (mag * t2 + C2 / 2) / C2;
                3: mag = odd ? (mag * t2 + S3 / 2) / S3 : (mag * t2 + C3 / 2) / C3;
                4: mag = odd ? (mag * t2 + S4 / 2) / S4 : (mag * t2 + C4 / 2) / C4;
                5: mag = odd ? (mag * t2 + S5 / 2) / S5 : (mag * t2 + C5 / 2) / C5;
                6: mag = odd ? (mag * t2 + S6 / 2) / S6 : (mag * t2 + C6 / 2) / C6;
                7: mag = odd ? (mag * t2 + S7 / 2) / S7 : (mag * t2 + C7 / 2) / C7;
                default: mag = mag;
            endcase
            if (i % 2 == 1)
                s = s - longint'(mag);
            else
                s = s + longint'(mag);
        end
        // round half up from q.24 to q.16, then saturate to q2.16
        r = (s + 128) >>> 8;
        if (r > STEP_MAX)
            r = STEP_MAX;
        if (r < STEP_MIN)
            r = STEP_MIN;
        return step_t'(r);
    endfunction

    function automatic step_tab_t build_tab(logic odd);
        step_tab_t       tab;
        longint unsigned t;
        for (int a = 0; a < RAY_COUNT; a++)
        begin
            t = (longint'(a) * 2 * PI_Q24 + RAY_COUNT / 2) / RAY_COUNT;
            tab[a] = taylor_q16(t, odd);
        end
        return tab;
    endfunction

    localparam step_tab_t COS_TAB = build_tab(1'b0);
    localparam step_tab_t SIN_TAB = build_tab(1'b1);

    always_ff @(posedge clk)
    begin
        step_x <= COS_TAB[ray];
        step_y <= SIN_TAB[ray];
    end

endmodule

`default_nettype wire

>>> design/grv_cell_store.sv
// cell store: wall memory and mark memory (visible, seen), one shared
// write address and one shared read address, registered reads; uses grv_pkg
`default_nettype none

module grv_cell_store #(
    parameter int MAP_WIDTH  = grv_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grv_pkg::MAP_HEIGHT_DEF
) (
    input  logic                                      clk,
    input  grv_pkg::store_ctl_t                       ctl,
    input  logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0]   waddr,
    input  logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0]   raddr,
    output logic                                      wall_q,
    output grv_pkg::mark_t                            mark_q
);
    import grv_pkg::*;

    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;

    logic  wall_mem [CELLS];
    mark_t mark_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (ctl.wall_we)
            wall_mem[waddr] <= ctl.wall_wd;
        wall_q <= wall_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mark_we)
            mark_mem[waddr] <= ctl.mark_wd;
        mark_q <= mark_mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/grv_ray_walker.sv
// ray walker: uses grv_pkg; steps every ray from the origin, one step a cycle
// unless a wall hit cancels it; walls are read the cycle before the mark write
`default_nettype none

module grv_ray_walker #(
    parameter int MAP_WIDTH  = grv_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grv_pkg::MAP_HEIGHT_DEF,
    parameter int RAY_COUNT  = grv_pkg::RAY_COUNT_DEF,
    parameter int MAX_RADIUS = grv_pkg::MAX_RADIUS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    go,
    input  logic [$clog2(MAP_WIDTH)-1:0]            origin_x,
    input  logic [$clog2(MAP_HEIGHT)-1:0]           origin_y,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]         radius,
    input  grv_pkg::step_t                          step_x,
    input  grv_pkg::step_t                          step_y,
    input  logic                                    wall_q,
    output logic [$clog2(RAY_COUNT)-1:0]            rom_addr,
    output logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0] raddr,
    output logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0] waddr,
    output grv_pkg::walk_stat_t                     stat
);
    import grv_pkg::*;

    localparam int X_W    = $clog2(MAP_WIDTH);
    localparam int Y_W    = $clog2(MAP_HEIGHT);
    localparam int ADDR_W = $clog2(MAP_WIDTH * MAP_HEIGHT);
    localparam int RAY_W  = $clog2(RAY_COUNT);
    localparam int K_W    = $clog2(MAX_RADIUS + 1);
    localparam int INT_W  = POS_W - FRAC_W;

    typedef enum logic [1:0] {
        W_IDLE,
        W_RUN,
        W_DRAIN
    } wstate_t;

    wstate_t             wstate_reg, wstate_next;
    logic [RAY_W-1:0]    ray_reg, ray_next;
    logic [K_W-1:0]      k_reg, k_next;
    pos_t                px_reg, px_next;
    pos_t                py_reg, py_next;
    logic                b_valid_reg, b_valid_next;
    logic                b_last_reg, b_last_next;
    logic [ADDR_W-1:0]   b_addr_reg, b_addr_next;

    pos_t              org_x, org_y;
    pos_t              np_x, np_y;
    logic              in_x, in_y;
    logic [X_W-1:0]    cx;
    logic [Y_W-1:0]    cy;
    logic [ADDR_W-1:0] step_addr;
    logic              last_k;
    logic              kill;
    logic              ray_end;

    assign org_x = pos_t'({origin_x, HALF_Q16});
    assign org_y = pos_t'({origin_y, HALF_Q16});

    assign np_x = px_reg + pos_t'(step_x);
    assign np_y = py_reg + pos_t'(step_y);

    // a position in (-1, 0) truncates to cell 0 and stays on the map
    assign in_x = np_x[POS_W-1]
                ? ((&np_x[POS_W-1:FRAC_W]) && (|np_x[FRAC_W-1:0]))
                : (np_x[POS_W-1:FRAC_W] < INT_W'(MAP_WIDTH));
    assign in_y = np_y[POS_W-1]
                ? ((&np_y[POS_W-1:FRAC_W]) && (|np_y[FRAC_W-1:0]))
                : (np_y[POS_W-1:FRAC_W] < INT_W'(MAP_HEIGHT));

    assign cx = np_x[POS_W-1] ? '0 : np_x[FRAC_W +: X_W];
    assign cy = np_y[POS_W-1] ? '0 : np_y[FRAC_W +: Y_W];

    assign step_addr = ADDR_W'(int'(cy) * MAP_WIDTH + int'(cx));
    assign last_k    = (K_W'(k_reg + 1'b1) == radius);

    // a wall hit on a step that is not the ray's last cancels the step behind it
    assign kill = b_valid_reg && wall_q && !b_last_reg;

    assign rom_addr     = ray_next;
    assign raddr        = step_addr;
    assign waddr        = b_addr_reg;
    assign stat.mark_we = b_valid_reg;
    assign stat.done    = (wstate_reg == W_DRAIN) && !b_valid_reg;

    always_comb
    begin
        wstate_next  = wstate_reg;
        ray_next     = ray_reg;
        k_next       = k_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        b_valid_next = 1'b0;
        b_last_next  = b_last_reg;
        b_addr_next  = b_addr_reg;
        ray_end      = 1'b0;
        case (wstate_reg)
            W_IDLE:
            begin
                ray_next = '0;
                if (go)
                begin
                    k_next      = '0;
                    px_next     = org_x;
                    py_next     = org_y;
                    wstate_next = (radius == '0) ? W_DRAIN : W_RUN;
                end
            end
            W_RUN:
            begin
                if (kill)
                    ray_end = 1'b1;
                else
                begin
                    b_valid_next = in_x && in_y;
                    b_addr_next  = step_addr;
                    b_last_next  = last_k;
                    if (!(in_x && in_y) || last_k)
                        ray_end = 1'b1;
                    else
                    begin
                        px_next = np_x;
                        py_next = np_y;
                        k_next  = k_reg + 1'b1;
                    end
                end
                if (ray_end)
                begin
                    k_next  = '0;
                    px_next = org_x;
                    py_next = org_y;
                    if (ray_reg == RAY_W'(RAY_COUNT - 1))
                    begin
                        ray_next    = '0;
                        wstate_next = W_DRAIN;
                    end
                    else
                        ray_next = ray_reg + 1'b1;
                end
            end
            W_DRAIN:
            begin
                if (!b_valid_reg)
                    wstate_next = W_IDLE;
            end
            default:
                wstate_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wstate_reg  <= W_IDLE;
            ray_reg     <= '0;
            k_reg       <= '0;
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end
        else
        begin
            wstate_reg  <= wstate_next;
            ray_reg     <= ray_next;
            k_reg       <= k_next;
            b_valid_reg <= b_valid_next;
            b_last_reg  <= b_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        b_addr_reg <= b_addr_next;
    end

endmodule

`default_nettype wire

>>> design/grid_raycast_visibility.sv
// top level of the grid visibility engine: command decode, memory sweeps
// and result strobe; uses grv_pkg, grv_cell_store, grv_step_rom, grv_ray_walker
`default_nettype none

// A request is taken on a clock edge with start high and busy low, and
// every request gives exactly one result, marked by done for one cycle;
// the receiver cannot stall it. Write and read never leave idle and their
// result shows in the cycle after the request is taken; a new request may
// follow at once. Clear all sweeps the cell memories one entry a cycle. A
// cast from a cell on the map first sweeps the visible marks (one
// read-modify-write a cycle), marks the origin, and then walks the rays
// at one step a cycle through the wall memory read port, except that a
// ray that stops on a wall before its last step cancels the step behind
// it; no ray walks more than R steps, with R = min(view_radius,
// MAX_RADIUS). After reset the block clears its memories with busy high;
// view_radius may be written at any time the block is idle.
module grid_raycast_visibility #(
    parameter int MAP_WIDTH  = grv_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grv_pkg::MAP_HEIGHT_DEF,
    parameter int RAY_COUNT  = grv_pkg::RAY_COUNT_DEF,
    parameter int MAX_RADIUS = grv_pkg::MAX_RADIUS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [grv_pkg::OP_W-1:0]      operation,
    input  logic [grv_pkg::COORD_W-1:0]   cell_x,
    input  logic [grv_pkg::COORD_W-1:0]   cell_y,
    input  logic                          wall_bit,
    output logic                          done,
    output logic                          is_wall,
    output logic                          is_visible,
    output logic                          was_seen,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [grv_pkg::CFG_W-1:0]     cfg_data
);
    import grv_pkg::*;

    localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int X_W    = $clog2(MAP_WIDTH);
    localparam int Y_W    = $clog2(MAP_HEIGHT);
    localparam int RAY_W  = $clog2(RAY_COUNT);
    localparam int K_W    = $clog2(MAX_RADIUS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_VSWEEP,
        ST_ORIGIN,
        ST_WALK
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              clr_op_reg, clr_op_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic [X_W-1:0]    org_x_reg, org_x_next;
    logic [Y_W-1:0]    org_y_reg, org_y_next;
    logic              done_reg, done_next;
    logic              rd_reg, rd_next;
    logic [CFG_W-1:0]  view_radius_reg;

    op_t               op;
    logic              accept;
    logic              in_map;
    logic [ADDR_W-1:0] op_addr;
    logic [ADDR_W-1:0] org_addr;
    logic [K_W-1:0]    radius;

    store_ctl_t        ctl;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              wall_q;
    mark_t             mark_q;

    logic              walk_go;
    logic [RAY_W-1:0]  rom_addr;
    step_t             step_x;
    step_t             step_y;
    logic [ADDR_W-1:0] walk_raddr;
    logic [ADDR_W-1:0] walk_waddr;
    walk_stat_t        walk_stat;

    assign op       = op_t'(operation);
    assign accept   = start && !busy;
    assign in_map   = (int'(cell_x) < MAP_WIDTH) && (int'(cell_y) < MAP_HEIGHT);
    assign op_addr  = ADDR_W'(int'(cell_y) * MAP_WIDTH + int'(cell_x));
    assign org_addr = ADDR_W'(int'(org_y_reg) * MAP_WIDTH + int'(org_x_reg));
    assign radius   = (int'(view_radius_reg) > MAX_RADIUS) ? K_W'(MAX_RADIUS)
                                                           : K_W'(view_radius_reg);

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign is_wall    = rd_reg && wall_q;
    assign is_visible = rd_reg && mark_q.vis;
    assign was_seen   = rd_reg && mark_q.seen;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            view_radius_reg <= VIEW_RADIUS_RST;
        else if (cfg_valid && cfg_ready)
            view_radius_reg <= cfg_data;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_op_next   = clr_op_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        org_x_next    = org_x_reg;
        org_y_next    = org_y_reg;
        done_next     = 1'b0;
        rd_next       = 1'b0;
        walk_go       = 1'b0;
        ctl           = '0;
        waddr         = op_addr;
        raddr         = op_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_WRITE:
                        begin
                            ctl.wall_we = in_map;
                            ctl.wall_wd = wall_bit;
                            ctl.mark_we = in_map;
                            done_next   = 1'b1;
                        end
                        OP_READ:
                        begin
                            rd_next   = in_map;
                            done_next = 1'b1;
                        end
                        OP_CAST:
                        begin
                            if (in_map)
                            begin
                                org_x_next = X_W'(cell_x);
                                org_y_next = Y_W'(cell_y);
                                cnt_next   = '0;
                                state_next = ST_VSWEEP;
                            end
                            else
                                done_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next    = '0;
                            clr_op_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ctl.wall_we = 1'b1;
                ctl.mark_we = 1'b1;
                waddr       = cnt_reg[ADDR_W-1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    done_next   = clr_op_reg;
                    clr_op_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            ST_VSWEEP:
            begin
                // read one entry, write it back in the next cycle with the visible mark cleared
                raddr            = cnt_reg[ADDR_W-1:0];
                waddr            = wb_addr_reg;
                ctl.mark_we      = wb_valid_reg;
                ctl.mark_wd.seen = mark_q.seen;
                if (cnt_reg < CNT_W'(CELLS))
                begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cnt_reg[ADDR_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                    state_next = ST_ORIGIN;
            end
            ST_ORIGIN:
            begin
                waddr            = org_addr;
                ctl.mark_we      = 1'b1;
                ctl.mark_wd.vis  = 1'b1;
                ctl.mark_wd.seen = 1'b1;
                walk_go          = 1'b1;
                state_next       = ST_WALK;
            end
            ST_WALK:
            begin
                raddr            = walk_raddr;
                waddr            = walk_waddr;
                ctl.mark_we      = walk_stat.mark_we;
                ctl.mark_wd.vis  = 1'b1;
                ctl.mark_wd.seen = 1'b1;
                if (walk_stat.done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            clr_op_reg   <= 1'b0;
            wb_valid_reg <= 1'b0;
            wb_addr_reg  <= '0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            done_reg     <= 1'b0;
            rd_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_op_reg   <= clr_op_next;
            wb_valid_reg <= wb_valid_next;
            wb_addr_reg  <= wb_addr_next;
            org_x_reg    <= org_x_next;
            org_y_reg    <= org_y_next;
            done_reg     <= done_next;
            rd_reg       <= rd_next;
        end
    end

    grv_cell_store #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_store (
        .clk    (clk),
        .ctl    (ctl),
        .waddr  (waddr),
        .raddr  (raddr),
        .wall_q (wall_q),
        .mark_q (mark_q)
    );

    grv_step_rom #(
        .RAY_COUNT (RAY_COUNT)
    ) u_rom (
        .clk    (clk),
        .ray    (rom_addr),
        .step_x (step_x),
        .step_y (step_y)
    );

    grv_ray_walker #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .RAY_COUNT  (RAY_COUNT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (walk_go),
        .origin_x (org_x_reg),
        .origin_y (org_y_reg),
        .radius   (radius),
        .step_x   (step_x),
        .step_y   (step_y),
        .wall_q   (wall_q),
        .rom_addr (rom_addr),
        .raddr    (walk_raddr),
        .waddr    (walk_waddr),
        .stat     (walk_stat)
    );

    // a result only leaves the block once it is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a cast from a cell on the map keeps the block busy
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CAST && in_map) |=> busy)
        else $error("cast request did not start");

    // the walker finishes only inside a cast
    a_walk_owner: assert property (@(posedge clk) disable iff (!rst_n)
        walk_stat.done |-> state_reg == ST_WALK)
        else $error("walker finished outside a cast");

    // wall bits never change while rays read them
    a_wall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK || state_reg == ST_VSWEEP) |-> !ctl.wall_we)
        else $error("wall memory written during a cast");

    // read data only shows with the strobe
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!is_wall && !is_visible && !was_seen))
        else $error("result fields set without strobe");

endmodule

`default_nettype wire
